// ===== sv/xtea_pkg.sv =====
// Package for the XTEA block decryptor: word and key types, round constants,
// configuration register indexes and the per-step sum helper.
// No dependencies.
package xtea_pkg;

	localparam int unsigned XTEA_ROUNDS   = 32;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned KEY_WORDS     = 4;
	localparam int unsigned CFG_IDX_W     = 4;

	localparam logic [WORD_W-1:0] XTEA_DELTA     = 32'h9E3779B9;
	localparam logic [WORD_W-1:0] XTEA_DELTA_NEG = 32'h61C88647;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [KEY_WORDS-1:0][WORD_W-1:0] xtea_key_t;

	// One 64-bit block moving down the pipeline
	typedef struct packed {
		word_t v0;
		word_t v1;
	} xtea_blk_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		KEY_IDX_0 = 4'd0,
		KEY_IDX_1 = 4'd1,
		KEY_IDX_2 = 4'd2,
		KEY_IDX_3 = 4'd3
	} cfg_idx_t;

	// Running sum after 'steps' decrements, starting at rounds * delta (mod 2^32)
	function automatic word_t xtea_sum(input int unsigned rounds, input int unsigned steps);
		logic [63:0] acc;
		acc = 64'(rounds) * 64'(XTEA_DELTA) + 64'(steps) * 64'(XTEA_DELTA_NEG);
		return acc[WORD_W-1:0];
	endfunction

endpackage

// ===== sv/xtea_if.sv =====
// Handshake interfaces of the XTEA decryptor: ciphertext in, plaintext out,
// key register writes. Depends on xtea_pkg.
interface xtea_cipher_if;
	logic              valid;
	logic              ready;
	xtea_pkg::word_t   cipher_word_0;
	xtea_pkg::word_t   cipher_word_1;

	modport source (output valid, output cipher_word_0, output cipher_word_1, input ready);
	modport sink   (input valid, input cipher_word_0, input cipher_word_1, output ready);
endinterface

interface xtea_plain_if;
	logic              valid;
	logic              ready;
	xtea_pkg::word_t   plain_word_0;
	xtea_pkg::word_t   plain_word_1;

	modport source (output valid, output plain_word_0, output plain_word_1, input ready);
	modport sink   (input valid, input plain_word_0, input plain_word_1, output ready);
endinterface

interface xtea_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [xtea_pkg::CFG_IDX_W-1:0]      index;
	xtea_pkg::word_t                     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/xtea_key_regs.sv =====
// Key register file of the XTEA decryptor: four 32-bit key words written
// over the configuration channel. Depends on xtea_pkg and xtea_if.
module xtea_key_regs (
	input  logic               clk,
	input  logic               arst_n,
	xtea_cfg_if.sink           cfg,
	output xtea_pkg::xtea_key_t key
);
	import xtea_pkg::*;

	xtea_key_t key_q;
	logic      wr_en;

	assign cfg.ready = 1'b1;
	assign wr_en     = cfg.valid & cfg.ready;
	assign key       = key_q;

	// Register write; indexes past the key words are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			case (cfg.index)
				KEY_IDX_0: key_q[0] <= cfg.data;
				KEY_IDX_1: key_q[1] <= cfg.data;
				KEY_IDX_2: key_q[2] <= cfg.data;
				KEY_IDX_3: key_q[3] <= cfg.data;
				default:   key_q    <= key_q;
			endcase
		end
	end

	a_key0_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && cfg.index == KEY_IDX_0 |=> key_q[0] == $past(cfg.data))
		else $error("key word 0 not updated");
	a_key3_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && cfg.index == KEY_IDX_3 |=> key_q[3] == $past(cfg.data))
		else $error("key word 3 not updated");
	a_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_en |=> $stable(key_q))
		else $error("key changed without a write");

endmodule

// ===== sv/xtea_half_round.sv =====
// One pipeline stage of XTEA decryption: a half round that updates one word
// using a fixed sum and key lane. Depends on xtea_pkg.
module xtea_half_round #(
	parameter xtea_pkg::word_t SUM     = '0,
	parameter bit              UPD_V0  = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  xtea_pkg::xtea_key_t  key,
	input  logic                 in_valid,
	input  xtea_pkg::xtea_blk_t  in_blk,
	output logic                 out_valid,
	output xtea_pkg::xtea_blk_t  out_blk
);
	import xtea_pkg::*;

	// Key lane is fixed per stage: bits 12:11 of the sum for the v1 half, 1:0 for v0
	localparam logic [1:0] KSEL = UPD_V0 ? SUM[1:0] : SUM[12:11];

	word_t     src, mix, sk, delta;
	xtea_blk_t nxt;
	logic      valid_s1;
	xtea_blk_t blk_s1;

	// Feistel half: mix the other word, xor with sum+key, subtract
	always_comb begin
		src   = UPD_V0 ? in_blk.v1 : in_blk.v0;
		mix   = ((src << 4) ^ (src >> 5)) + src;
		sk    = SUM + key[KSEL];
		delta = mix ^ sk;
		nxt   = in_blk;
		if (UPD_V0) begin
			nxt.v0 = in_blk.v0 - delta;
		end else begin
			nxt.v1 = in_blk.v1 - delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blk_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_blk   = blk_s1;

endmodule

// ===== sv/xtea_block_decrypt.sv =====
// Top level of the XTEA block decryptor: key registers plus a pipeline of
// 2*ROUNDS half-round stages. Depends on xtea_pkg, xtea_if, xtea_key_regs, xtea_half_round.

// Decrypts one 64-bit XTEA block per transaction with the 128-bit key in
// registers 0..3. The datapath is fully unrolled into 2*ROUNDS register stages,
// one half round each, so a block is accepted every cycle unless the pipeline
// is halted, and each block passes through every stage in order. The whole
// pipeline advances together; it halts only when the final stage holds a block
// the sink has not taken. Key writes must happen while the pipeline is empty.
module xtea_block_decrypt #(
	parameter int unsigned ROUNDS = xtea_pkg::XTEA_ROUNDS
) (
	input  logic          clk,
	input  logic          arst_n,
	xtea_cipher_if.sink   cipher,
	xtea_plain_if.source  plain,
	xtea_cfg_if.sink      cfg
);
	import xtea_pkg::*;

	localparam int unsigned STAGES = 2 * ROUNDS;

	xtea_key_t           key;
	logic [STAGES:0]     stage_vld;
	xtea_blk_t           stage_blk [0:STAGES];
	logic                pipe_en;

	xtea_key_regs u_keys (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.key    (key)
	);

	// Global advance: move unless the output stage is full and stalled
	assign pipe_en      = !stage_vld[STAGES] || plain.ready;
	assign cipher.ready = pipe_en;

	assign stage_vld[0]    = cipher.valid;
	assign stage_blk[0].v0 = cipher.cipher_word_0;
	assign stage_blk[0].v1 = cipher.cipher_word_1;

	// Half-round stages; even stage updates v1, odd stage updates v0
	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		localparam int unsigned RND = j / 2;
		localparam bit          ODD = (j % 2) == 1;
		localparam word_t       SUM = xtea_sum(ROUNDS, ODD ? RND + 1 : RND);

		xtea_half_round #(
			.SUM    (SUM),
			.UPD_V0 (ODD)
		) u_half (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.key       (key),
			.in_valid  (stage_vld[j]),
			.in_blk    (stage_blk[j]),
			.out_valid (stage_vld[j+1]),
			.out_blk   (stage_blk[j+1])
		);
	end

	assign plain.valid        = stage_vld[STAGES];
	assign plain.plain_word_0 = stage_blk[STAGES].v0;
	assign plain.plain_word_1 = stage_blk[STAGES].v1;

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		cipher.valid && cipher.ready |=> stage_vld[1])
		else $error("accepted block missing from first stage");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(stage_vld[STAGES:1]))
		else $error("pipeline valids moved during stall");
	a_arrive: assert property (@(posedge clk) disable iff (!arst_n)
		stage_vld[STAGES-1] && pipe_en |=> plain.valid)
		else $error("block lost before output stage");

endmodule

// ===== tb/sv/tb_xtea_block_decrypt.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for xtea_block_decrypt: drives ciphertext blocks and key writes,
// predicts each plaintext with its own XTEA decryption and checks every result in order.
// Depends on xtea_pkg, xtea_if and the xtea_block_decrypt RTL.
module tb_xtea_block_decrypt;
	import xtea_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASES = 5;
	localparam int unsigned BLOCKS_PER_PHASE = 200;
	// register indexes past the key words; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] IDX_PAST_KEYS = CFG_IDX_W'(KEY_WORDS);
	localparam logic [CFG_IDX_W-1:0] IDX_TOP = '1;

	typedef struct {
		word_t w0;
		word_t w1;
	} cipher_row_t;

	// Directed blocks: field extremes, single bits, alternating patterns.
	// No plaintext here is obvious by inspection, so every row goes through the predictor.
	cipher_row_t directed_rows [12] = '{
		'{32'h0000_0000, 32'h0000_0000},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{32'h0000_0000, 32'hFFFF_FFFF},
		'{32'hFFFF_FFFF, 32'h0000_0000},
		'{32'h8000_0000, 32'h0000_0001},
		'{32'h0000_0001, 32'h8000_0000},
		'{32'hAAAA_AAAA, 32'h5555_5555},
		'{32'h5555_5555, 32'hAAAA_AAAA},
		'{32'h7FFF_FFFF, 32'hFFFF_FFFE},
		'{32'hDEAD_BEEF, 32'h0123_4567},
		'{32'h4142_4344, 32'h4546_4748},
		'{32'h0000_8000, 32'h0001_0000}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	xtea_cipher_if cipher_bus ();
	xtea_plain_if  plain_bus ();
	xtea_cfg_if    cfg_bus ();

	xtea_block_decrypt dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cipher (cipher_bus),
		.plain  (plain_bus),
		.cfg    (cfg_bus)
	);

	word_t       key_shadow [KEY_WORDS];
	xtea_blk_t   expected_plain [$];
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	bit          send_burst = 1'b0;
	bit          sink_burst = 1'b0;
	int          sink_wait = 0;

	always #4 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// 32-round XTEA decryption of one block with the shadow key
	function automatic xtea_blk_t decrypt_block(input word_t c0, input word_t c1);
		word_t     v0;
		word_t     v1;
		word_t     sum;
		xtea_blk_t blk;
		v0 = c0;
		v1 = c1;
		sum = word_t'(XTEA_ROUNDS) * XTEA_DELTA;
		for (int r = 0; r < XTEA_ROUNDS; r++) begin
			v1 -= (((v0 << 4) ^ (v0 >> 5)) + v0) ^ (sum + key_shadow[sum[12:11]]);
			sum += XTEA_DELTA_NEG;
			v0 -= (((v1 << 4) ^ (v1 >> 5)) + v1) ^ (sum + key_shadow[sum[1:0]]);
		end
		blk.v0 = v0;
		blk.v1 = v1;
		return blk;
	endfunction

	// Random word biased toward zero, all ones and single set/clear bits
	function automatic word_t pick_word();
		int unsigned b;
		b = $urandom_range(0, WORD_W - 1);
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return word_t'(1) << b;
			end
			3: begin
				return ~(word_t'(1) << b);
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	// One register write transaction; valid stays up for the caller to drop
	task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input word_t value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		if (idx < KEY_WORDS)
			key_shadow[idx[1:0]] = value;
	endtask

	// Full key load in a random order, sometimes with a stray write past the key words
	task automatic load_key_set(input word_t keys [KEY_WORDS]);
		int unsigned start;
		int unsigned slot;
		start = $urandom_range(0, KEY_WORDS - 1);
		if ($urandom_range(0, 1))
			write_key(CFG_IDX_W'($urandom_range(KEY_WORDS, 2**CFG_IDX_W - 1)), pick_word());
		for (int k = 0; k < KEY_WORDS; k++) begin
			slot = (start + k) % KEY_WORDS;
			write_key(cfg_idx_t'(slot), keys[slot]);
		end
		if ($urandom_range(0, 1))
			write_key(CFG_IDX_W'($urandom_range(KEY_WORDS, 2**CFG_IDX_W - 1)), pick_word());
		cfg_bus.valid <= 1'b0;
	endtask

	// One ciphertext transaction after a random idle gap; valid stays up after acceptance
	task automatic send_block(input word_t w0, input word_t w1);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			cipher_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cipher_bus.valid <= 1'b1;
		cipher_bus.cipher_word_0 <= w0;
		cipher_bus.cipher_word_1 <= w1;
		do @(posedge clk); while (!cipher_bus.ready);
		expected_plain.push_back(decrypt_block(w0, w1));
	endtask

	// Drop valid and wait until every plaintext has come back
	task automatic drain_pipeline();
		cipher_bus.valid <= 1'b0;
		while (expected_plain.size() != 0)
			@(posedge clk);
	endtask

	// Plaintext check and output stalls
	always @(posedge clk or negedge arst_n) begin
		xtea_blk_t want;
		if (!arst_n) begin
			plain_bus.ready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (plain_bus.valid && plain_bus.ready) begin
				if (expected_plain.size() == 0) begin
					$display("%0t: unexpected plaintext %h %h", $time,
						plain_bus.plain_word_0, plain_bus.plain_word_1);
					errors++;
				end else begin
					want = expected_plain.pop_front();
					if (plain_bus.plain_word_0 !== want.v0) begin
						$display("%0t: plain_word_0 expected %h actual %h", $time,
							want.v0, plain_bus.plain_word_0);
						errors++;
					end
					if (plain_bus.plain_word_1 !== want.v1) begin
						$display("%0t: plain_word_1 expected %h actual %h", $time,
							want.v1, plain_bus.plain_word_1);
						errors++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					sink_burst = !sink_burst;
				sink_wait = sink_burst ? 0 : $urandom_range(0, 11);
			end
			if (sink_wait > 0) begin
				plain_bus.ready <= 1'b0;
				sink_wait--;
			end else begin
				plain_bus.ready <= 1'b1;
			end
		end
	end

	// Stimulus sequence
	initial begin
		word_t keys [KEY_WORDS];
		cipher_bus.valid <= 1'b0;
		cipher_bus.cipher_word_0 <= '0;
		cipher_bus.cipher_word_1 <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= KEY_IDX_0;
		cfg_bus.data <= '0;
		foreach (key_shadow[k])
			key_shadow[k] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed blocks with the key left at its reset value
		foreach (directed_rows[i])
			send_block(directed_rows[i].w0, directed_rows[i].w1);
		drain_pipeline();

		// all-ones key, then writes past the key words that must not touch it
		write_key(KEY_IDX_0, '1);
		write_key(KEY_IDX_1, '1);
		write_key(KEY_IDX_2, '1);
		write_key(KEY_IDX_3, '1);
		write_key(IDX_PAST_KEYS, '0);
		write_key(IDX_TOP, '0);
		cfg_bus.valid <= 1'b0;
		foreach (directed_rows[i])
			send_block(directed_rows[i].w0, directed_rows[i].w1);
		drain_pipeline();

		// random phases, each under a new key
		for (int p = 0; p < PHASES; p++) begin
			for (int k = 0; k < KEY_WORDS; k++) begin
				if (p == 0)
					keys[k] = (k % 2) ? '1 : '0;
				else if (p == 1)
					keys[k] = (k % 2) ? '0 : '1;
				else
					keys[k] = pick_word();
			end
			load_key_set(keys);
			for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
				// in the third phase, hold off mid-phase until the pipeline is empty
				if (p == 2 && n == BLOCKS_PER_PHASE / 2)
					drain_pipeline();
				send_block(pick_word(), pick_word());
			end
			drain_pipeline();
		end

		repeat (2 * XTEA_ROUNDS + 16) @(posedge clk);
		if (errors == 0 && expected_plain.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
